### src/assert_macros.svh
// assertion macros shared by the table rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kvt_pkg.sv
// package for the integer key value table: codes, widths, defaults, command struct
// no dependencies
package kvt_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_SET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } kvt_cmd_t;

endpackage

### src/kvt_ctrl.sv
// controller state machine for the key value table
// depends on kvt_pkg
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output kvt_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_ok;

    assign load_ok     = (state_reg == S_LOAD) && (!out_valid_reg || !out_stall);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.load    = load_ok;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/kvt_dpath.sv
// datapath for the key value table: key lanes, valid bits, value memory, count, result word
// depends on kvt_pkg
module kvt_dpath
    import kvt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  kvt_cmd_t                 cmd,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [VALUE_W-1:0]       value,
    output logic [STAT_W-1:0]        status,
    output logic [VALUE_W-1:0]       read_value,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_W-1:0]      key_lane_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]      count_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_in_reg;
    logic [VALUE_W-1:0]    value_in_reg;
    logic [ENTRIES-1:0]    match_reg;
    logic [ENTRIES-1:0]    free_reg;

    logic [STAT_W-1:0]     res_status_reg;
    logic                  res_get_hit_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [COUNT_W-1:0]    entry_count_reg;

    logic                  hit;
    logic                  free_any;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic                  mem_we;
    logic                  mem_re;
    logic                  claim;
    logic                  release_slot;
    logic [STAT_W-1:0]     exec_status;
    logic [VALUE_BITS-1:0] wr_data;

    assign hit      = |match_reg;
    assign free_any = |free_reg;
    assign wr_idx   = hit ? hit_idx : free_idx;
    assign wr_data  = VALUE_BITS'({{VALUE_BITS{1'b0}}, value_in_reg});

    // lowest matching lane and lowest free lane
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        claim        = 1'b0;
        release_slot = 1'b0;
        exec_status  = ST_OK;
        case (func_reg)
            FUNC_SET:
            begin
                if (hit)
                begin
                    mem_we = 1'b1;
                end
                else if (free_any)
                begin
                    mem_we = 1'b1;
                    claim  = 1'b1;
                end
                else
                begin
                    exec_status = ST_FULL;
                end
            end
            FUNC_GET:
            begin
                if (hit)
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    exec_status = ST_MISS;
                end
            end
            FUNC_DEL:
            begin
                if (hit)
                begin
                    release_slot = 1'b1;
                end
                else
                begin
                    exec_status = ST_MISS;
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // control state: valid bits and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (claim)
            begin
                valid_reg[free_idx] <= 1'b1;
                count_reg           <= CNT_W'(count_reg + 1'b1);
            end
            else if (release_slot)
            begin
                valid_reg[hit_idx] <= 1'b0;
                count_reg          <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    // request capture and per-lane key compare
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func;
            key_in_reg   <= $unsigned(key);
            value_in_reg <= value;
            free_reg     <= ~valid_reg;
            for (int i = 0; i < ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (key_lane_reg[i] == $unsigned(key));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && claim)
        begin
            key_lane_reg[free_idx] <= key_in_reg;
        end
    end

    // value memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            value_mem[wr_idx] <= wr_data;
        end
        if (cmd.exec && mem_re)
        begin
            rd_data_reg <= value_mem[hit_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg  <= exec_status;
            res_get_hit_reg <= mem_re;
        end
        if (cmd.load)
        begin
            status_reg      <= res_status_reg;
            read_value_reg  <= res_get_hit_reg ? VALUE_W'({{VALUE_W{1'b0}}, rd_data_reg})
                                               : '0;
            entry_count_reg <= COUNT_W'({{COUNT_W{1'b0}}, count_reg});
        end
    end

    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

endmodule

### src/integer_key_value_table_top.sv
// top level of the integer key value table: controller plus datapath
// depends on kvt_pkg, kvt_ctrl, kvt_dpath, assert_macros.svh
//
//   channel   handshake               word fields
//   in        in_valid / in_stall     func, key, value
//   out       out_valid / out_stall   status, read_value, entry_count
//
// a request runs in order: the accept edge registers the per-lane key compare,
// the execute state updates valid bits, key lanes and the value memory (read on a get),
// and the load state loads the output register; the next word is taken after that
// a stalled result holds the load cycle until the output register frees up
// reset clears the valid bits and the count at once, keys and values need no clear
`include "assert_macros.svh"

module integer_key_value_table_top
    import kvt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [VALUE_W-1:0]       value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [VALUE_W-1:0]       read_value,
    output logic [COUNT_W-1:0]       entry_count
);

    kvt_cmd_t cmd;

    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kvt_dpath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .key         (key),
        .value       (value),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    `KVT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall && cmd.exec, "no execute after accept")
    `KVT_ASSERT_NEXT(a_load_shows_word, clk, rst_n, cmd.load, out_valid, "loaded result not presented")
    `KVT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (status == ST_OK) || (status == ST_MISS) || (status == ST_FULL), "bad status code")
    `KVT_ASSERT_NOW(a_zero_on_fail, clk, rst_n, out_valid && (status != ST_OK), read_value == '0, "read value set on failed request")
    `KVT_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid && (ENTRIES < 32), 32'(entry_count) <= ENTRIES, "entry count above table size")

endmodule

### tb/tb.sv
// self-checking testbench for integer_key_value_table_top: directed and random set/get/delete
// words with random idling on both channels, checked by a scoreboard that models the table
// depends on kvt_pkg and integer_key_value_table_top
`timescale 1ns / 1ps

module tb;
    import kvt_pkg::*;

    localparam int SLOTS = DEF_ENTRIES;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] entry_count;
    } kv_result_t;

    class kv_scoreboard;
        logic               live [SLOTS];
        logic [KEY_W-1:0]   keys [SLOTS];
        logic [VALUE_W-1:0] vals [SLOTS];
        int                 occupied;
        kv_result_t         pending [$];
        int                 errors;
        int                 op_count [4];
        int                 hits;
        int                 misses;
        int                 refusals;
        int                 peak;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                live[i] = 1'b0;
            end
            occupied = 0;
            errors = 0;
            hits = 0;
            misses = 0;
            refusals = 0;
            peak = 0;
            for (int i = 0; i < 4; i++)
            begin
                op_count[i] = 0;
            end
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                   logic [VALUE_W-1:0] v);
            int hit;
            int free_slot;
            kv_result_t r;
            hit = -1;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && live[i] && keys[i] == k)
                    hit = i;
                if (free_slot < 0 && !live[i])
                    free_slot = i;
            end
            r.status = ST_OK;
            r.read_value = '0;
            op_count[f]++;
            case (f)
                FUNC_SET:
                begin
                    if (hit >= 0)
                    begin
                        vals[hit] = v;
                        hits++;
                    end
                    else if (free_slot < 0)
                    begin
                        r.status = ST_FULL;
                        refusals++;
                    end
                    else
                    begin
                        live[free_slot] = 1'b1;
                        keys[free_slot] = k;
                        vals[free_slot] = v;
                        occupied++;
                    end
                end
                FUNC_GET:
                begin
                    if (hit >= 0)
                    begin
                        r.read_value = vals[hit];
                        hits++;
                    end
                    else
                    begin
                        r.status = ST_MISS;
                        misses++;
                    end
                end
                FUNC_DEL:
                begin
                    if (hit >= 0)
                    begin
                        live[hit] = 1'b0;
                        occupied--;
                        hits++;
                    end
                    else
                    begin
                        r.status = ST_MISS;
                        misses++;
                    end
                end
                default:
                begin
                end
            endcase
            if (occupied > peak)
                peak = occupied;
            r.entry_count = occupied[COUNT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [VALUE_W-1:0] rv,
                                   logic [COUNT_W-1:0] cnt);
            kv_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result word with nothing pending: status %0d value %h count %0d",
                         $time, st, rv, cnt);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (rv !== e.read_value)
            begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value, rv);
                errors++;
            end
            if (cnt !== e.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func = FUNC_SET;
    logic signed [KEY_W-1:0]   key = '0;
    logic [VALUE_W-1:0]        value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STAT_W-1:0]         status;
    logic [VALUE_W-1:0]        read_value;
    logic [COUNT_W-1:0]        entry_count;

    kv_scoreboard              sb;
    logic [KEY_W-1:0]          key_pool [POOL_SIZE];
    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;

    integer_key_value_table_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key <= k;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(f, k, v);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(status, read_value, entry_count);
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        int roll;
        int fill_mode;
        logic [FUNC_W-1:0]  f;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;

        sb = new();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_stall_pct = 65;

        // fill every slot, then hit each corner once
        for (int i = 0; i < SLOTS; i++)
        begin
            send_word(FUNC_SET, key_pool[i], (i == 0) ? '0 : ((i == 1) ? '1 : $urandom()));
        end
        send_word(FUNC_SET, key_pool[16], $urandom());
        send_word(FUNC_SET, key_pool[1], '0);
        send_word(FUNC_GET, key_pool[1], '1);
        send_word(FUNC_GET, key_pool[16], '0);
        send_word(FUNC_DEL, key_pool[17], '0);
        send_word(FUNC_DEL, key_pool[0], '0);
        send_word(FUNC_NOP, key_pool[2], '1);
        send_word(FUNC_SET, key_pool[16], '1);
        send_word(FUNC_GET, key_pool[16], '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_stall_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS / 3; n++)
            begin
                // alternate stretches that fill the table and stretches that drain it
                fill_mode = ((n / 50) % 2 == 0);
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    f = FUNC_NOP;
                else if (roll < (fill_mode ? 60 : 25))
                    f = FUNC_SET;
                else if (roll < (fill_mode ? 85 : 55))
                    f = FUNC_GET;
                else
                    f = FUNC_DEL;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    v = '0;
                else if (roll == 1)
                    v = '1;
                else
                    v = $urandom();
                send_word(f, k, v);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sets, %0d gets, %0d deletes, %0d unused-code words",
                 sb.op_count[FUNC_SET], sb.op_count[FUNC_GET], sb.op_count[FUNC_DEL],
                 sb.op_count[FUNC_NOP]);
        $display("key hits %0d, misses %0d, full refusals %0d, peak occupancy %0d",
                 sb.hits, sb.misses, sb.refusals, sb.peak);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
